FILE: src/eegp2_pkg.sv
// shared constants and types for the p2 eeg frame parser
`default_nettype none

package eegp2_pkg;

    localparam int BLOCK_LEN = 256;
    localparam int CHANNELS  = 2;

    localparam int CNT_W   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int N_SLOTS = (CHANNELS >= 2) ? 4 : 2;
    localparam int SLOT_W  = $clog2(N_SLOTS);
    localparam int POS_W   = 5;

    localparam logic [7:0] SYNC_FIRST    = 8'hA5;
    localparam logic [7:0] SYNC_SECOND   = 8'h5A;
    localparam logic [7:0] FRAME_VERSION = 8'h02;
    localparam logic [7:0] TRAILER_A     = 8'h0F;
    localparam logic [7:0] TRAILER_B     = 8'hF0;

    localparam logic [POS_W-1:0] POS_SYNC1   = 5'd0;
    localparam logic [POS_W-1:0] POS_SYNC2   = 5'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 5'd2;
    localparam logic [POS_W-1:0] POS_COUNTER = 5'd3;
    localparam logic [POS_W-1:0] POS_DATA    = 5'd4;
    localparam logic [POS_W-1:0] POS_TRAILER = 5'd16;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample_ch1;
        logic signed [15:0] sample_ch2;
        logic [7:0]         sample_index;
        logic               block_last;
    } t_result;

endpackage

`default_nettype wire

FILE: src/eegp2_frame_parser.sv
// frame position tracking, channel byte store and sample counting
`default_nettype none

module eegp2_frame_parser import eegp2_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic       i_command,
    input  wire logic [7:0] i_rx_byte,
    output t_result         o_result
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_accepting, n_accepting;
    logic [7:0]       r_ch_bytes [N_SLOTS];

    logic [POS_W-1:0] slot;
    logic             store_en;
    logic             trailer_ok;
    logic             last;
    logic [31:0]      count_ext;
    logic signed [15:0] ch1_word;
    logic signed [15:0] ch2_word;

    assign slot      = r_pos - POS_DATA;
    assign count_ext = 32'(r_count);
    assign last      = (r_count == CNT_W'(BLOCK_LEN - 1));
    assign trailer_ok = (i_rx_byte == TRAILER_A) || (i_rx_byte == TRAILER_B);
    assign ch1_word  = {r_ch_bytes[0], r_ch_bytes[1]};

    generate
        if (CHANNELS >= 2) begin : g_ch2
            assign ch2_word = {r_ch_bytes[2], r_ch_bytes[3]};
        end else begin : g_no_ch2
            assign ch2_word = 16'sd0;
        end
    endgenerate

    always_comb begin
        n_pos       = r_pos;
        n_count     = r_count;
        n_accepting = r_accepting;
        store_en    = 1'b0;
        o_result    = '0;
        o_result.sample_ch1   = ch1_word;
        o_result.sample_ch2   = ch2_word;
        o_result.sample_index = count_ext[7:0];
        o_result.block_last   = last;
        if (i_step) begin
            if (i_command == CMD_RELEASE) begin
                n_accepting = 1'b1;
            end else if (r_accepting) begin
                if (r_pos == POS_SYNC1) begin
                    if (i_rx_byte == SYNC_FIRST) begin
                        n_pos = POS_SYNC2;
                    end
                end else if (r_pos == POS_SYNC2) begin
                    n_pos = (i_rx_byte == SYNC_SECOND) ? POS_VERSION : POS_SYNC1;
                end else if (r_pos == POS_VERSION) begin
                    n_pos = (i_rx_byte == FRAME_VERSION) ? POS_COUNTER : POS_SYNC1;
                end else if (r_pos == POS_COUNTER) begin
                    n_pos = POS_DATA;
                end else if (r_pos < POS_TRAILER) begin
                    store_en = (slot < POS_W'(N_SLOTS));
                    n_pos    = r_pos + 1'b1;
                end else begin
                    if (trailer_ok) begin
                        o_result.valid = 1'b1;
                        if (last) begin
                            n_count     = '0;
                            n_accepting = 1'b0;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    n_pos = POS_SYNC1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_SYNC1;
            r_count     <= '0;
            r_accepting <= 1'b1;
        end else begin
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_accepting <= n_accepting;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_ch_bytes[slot[SLOT_W-1:0]] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

FILE: src/eeg_p2_frame_parser_unit.sv
// top level of the p2 eeg frame parser: input word register, parser and result register
//
// input channel: i_valid / o_ready carry one word (i_command, i_rx_byte). a command of
// zero hands over a received serial byte, a command of one releases a finished block.
// output channel: o_valid / i_ready carry one sample word (both channel samples, the
// sample index within the block and the block_last flag) for each frame that ends in
// a good trailer; other words give no output.
// a word accepted at one clock edge is parsed at the next edge that finds the result
// register free or being emptied; a good trailer's sample enters the result register at that edge.
// one word is taken every cycle while the receiver keeps i_ready high.
// when the receiver stalls, the result register holds its sample and the input
// register holds one more word; o_ready then stays low until the sample is taken.
// after a block_last sample, received bytes are dropped until a release word.
// reset empties both registers, puts the parser back at the first sync byte, clears
// the sample count and resumes accepting bytes. stored channel bytes are not cleared.
`default_nettype none

module eeg_p2_frame_parser_unit import eegp2_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_sample_ch1,
    output logic signed [15:0] o_sample_ch2,
    output logic [7:0]       o_sample_index,
    output logic             o_block_last
);

    logic       r_in_valid;
    logic       r_in_command;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;
    t_result    result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    eegp2_frame_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_command (r_in_command),
        .i_rx_byte (r_in_byte),
        .o_result  (result)
    );

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_command <= i_command;
            r_in_byte    <= i_rx_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_ch1   = r_out.sample_ch1;
    assign o_sample_ch2   = r_out.sample_ch2;
    assign o_sample_index = r_out.sample_index;
    assign o_block_last   = r_out.block_last;

endmodule

`default_nettype wire

FILE: dv/p2_sample_checker.sv
// checker for the p2 eeg frame parser: predicts samples from accepted words and compares them
`timescale 1ns / 1ps

module p2_sample_checker import eegp2_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_word_valid,
    input  wire logic               i_word_ready,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic               i_sample_valid,
    input  wire logic               i_sample_ready,
    input  wire logic signed [15:0] i_sample_ch1,
    input  wire logic signed [15:0] i_sample_ch2,
    input  wire logic [7:0]         i_sample_index,
    input  wire logic               i_block_last,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic signed [15:0] ch1;
        logic signed [15:0] ch2;
        logic [7:0]         index;
        logic               last;
    } t_sample;

    logic [POS_W-1:0] frame_pos    = POS_SYNC1;
    logic [7:0]       chan_bytes [0:11];
    int unsigned      sample_count = 0;
    bit               accepting    = 1'b1;
    t_sample          expected_samples [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        foreach (chan_bytes[j]) begin
            chan_bytes[j] = 8'h00;
        end
    end

    function automatic bit frame_step(input logic cmd, input logic [7:0] b, output t_sample s);
        logic [3:0] slot;
        s = '0;
        if (cmd == CMD_RELEASE) begin
            accepting = 1'b1;
            return 1'b0;
        end
        if (!accepting) begin
            return 1'b0;
        end
        case (frame_pos)
            POS_SYNC1: begin
                if (b == SYNC_FIRST) frame_pos = POS_SYNC2;
            end
            POS_SYNC2: begin
                frame_pos = (b == SYNC_SECOND) ? POS_VERSION : POS_SYNC1;
            end
            POS_VERSION: begin
                frame_pos = (b == FRAME_VERSION) ? POS_COUNTER : POS_SYNC1;
            end
            POS_COUNTER: begin
                frame_pos = POS_DATA;
            end
            POS_TRAILER: begin
                frame_pos = POS_SYNC1;
                if (b == TRAILER_A || b == TRAILER_B) begin
                    s.ch1   = {chan_bytes[0], chan_bytes[1]};
                    s.ch2   = (CHANNELS >= 2) ? {chan_bytes[2], chan_bytes[3]} : 16'sd0;
                    s.index = sample_count[7:0];
                    s.last  = (sample_count + 1 >= BLOCK_LEN);
                    if (s.last) begin
                        sample_count = 0;
                        accepting    = 1'b0;
                    end else begin
                        sample_count = sample_count + 1;
                    end
                    return 1'b1;
                end
            end
            default: begin
                slot = 4'(frame_pos - POS_DATA);
                if (slot / 2 < CHANNELS) chan_bytes[slot] = b;
                frame_pos = frame_pos + 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (!i_rst_n) begin
            frame_pos    = POS_SYNC1;
            sample_count = 0;
            accepting    = 1'b1;
            expected_samples.delete();
        end else begin
            if (i_sample_valid && i_sample_ready) begin
                got = '{i_sample_ch1, i_sample_ch2, i_sample_index, i_block_last};
                if (expected_samples.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected sample, expected none", $time);
                    $display("%0t: actual ch1 %0d ch2 %0d index %0d last %0b",
                             $time, got.ch1, got.ch2, got.index, got.last);
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: sample mismatch, expected ch1 %0d ch2 %0d index %0d last %0b",
                                 $time, want.ch1, want.ch2, want.index, want.last);
                        $display("%0t: actual ch1 %0d ch2 %0d index %0d last %0b",
                                 $time, got.ch1, got.ch2, got.index, got.last);
                    end
                end
            end
            if (i_word_valid && i_word_ready) begin
                if (frame_step(i_command, i_rx_byte, want)) expected_samples.push_back(want);
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

FILE: dv/testbench.sv
// top of the p2 eeg frame parser testbench: clock, reset, word stimulus and verdict
`timescale 1ns / 1ps

module testbench import eegp2_pkg::*;;

    typedef enum int {
        FR_GOOD_A,
        FR_GOOD_B,
        FR_BAD_TRAILER,
        FR_BAD_SYNC,
        FR_BAD_VERSION
    } t_frame_kind;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              i_command = CMD_BYTE;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              i_ready   = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic signed [15:0] o_sample_ch1;
    logic signed [15:0] o_sample_ch2;
    logic [7:0]        o_sample_index;
    logic              o_block_last;

    int fail_count;
    int pending;
    bit quiet       = 1'b0;
    int good_frames = 0;

    always #6 i_clk = ~i_clk;

    eeg_p2_frame_parser_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_ch1   (o_sample_ch1),
        .o_sample_ch2   (o_sample_ch2),
        .o_sample_index (o_sample_index),
        .o_block_last   (o_block_last)
    );

    p2_sample_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word_valid   (i_valid),
        .i_word_ready   (o_ready),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_sample_valid (o_valid),
        .i_sample_ready (i_ready),
        .i_sample_ch1   (o_sample_ch1),
        .i_sample_ch2   (o_sample_ch2),
        .i_sample_index (o_sample_index),
        .i_block_last   (o_block_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic put_word(input logic cmd, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind, input logic [31:0] lead);
        logic [7:0] b;
        int i;
        put_word(CMD_BYTE, SYNC_FIRST);
        if (kind == FR_BAD_SYNC) begin
            b = 8'($urandom);
            if (b == SYNC_SECOND) b = ~b;
            put_word(CMD_BYTE, b);
            return;
        end
        put_word(CMD_BYTE, SYNC_SECOND);
        if (kind == FR_BAD_VERSION) begin
            b = 8'($urandom);
            if (b == FRAME_VERSION) b = ~b;
            put_word(CMD_BYTE, b);
            return;
        end
        put_word(CMD_BYTE, FRAME_VERSION);
        put_word(CMD_BYTE, 8'($urandom));
        for (i = 0; i < 12; i++) begin
            // stray release in mid frame
            if ($urandom_range(0, 60) == 0) put_word(CMD_RELEASE, 8'($urandom));
            put_word(CMD_BYTE, (i < 4) ? lead[31 - 8 * i -: 8] : rand_byte());
        end
        case (kind)
            FR_GOOD_A: b = TRAILER_A;
            FR_GOOD_B: b = TRAILER_B;
            default: begin
                b = 8'($urandom);
                if (b == TRAILER_A || b == TRAILER_B) b = 8'h00;
            end
        endcase
        if (kind == FR_GOOD_A || kind == FR_GOOD_B) good_frames++;
        put_word(CMD_BYTE, b);
    endtask

    // receiver side back-pressure
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int k;
        bit paused;
        paused = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        put_word(CMD_BYTE, 8'h00);
        put_word(CMD_BYTE, 8'hFF);
        put_word(CMD_BYTE, SYNC_SECOND);
        put_word(CMD_RELEASE, SYNC_FIRST);
        send_frame(FR_GOOD_A, 32'h8000_7FFF);
        send_frame(FR_GOOD_B, 32'h7FFF_8000);
        send_frame(FR_BAD_TRAILER, 32'hFFFF_0000);
        // doubled first sync loses the frame that follows
        put_word(CMD_BYTE, SYNC_FIRST);
        send_frame(FR_GOOD_A, 32'h1234_5678);
        send_frame(FR_BAD_SYNC, 32'h0);
        send_frame(FR_BAD_VERSION, 32'h0);
        send_frame(FR_GOOD_B, 32'hFFFF_0000);

        i_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);

        while (good_frames < 75) begin
            if (good_frames >= 66) quiet = 1'b1;
            if (good_frames == 30 && !paused) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            k = $urandom_range(0, 99);
            if (k < 4) begin
                put_word(CMD_RELEASE, 8'($urandom));
            end else if (k < 10) begin
                repeat ($urandom_range(1, 4)) begin
                    put_word(CMD_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_FIRST : rand_byte());
                end
            end else if (k < 16) begin
                send_frame(FR_BAD_TRAILER, {rand_byte(), rand_byte(), rand_byte(), rand_byte()});
            end else if (k < 20) begin
                send_frame(FR_BAD_SYNC, 32'h0);
            end else if (k < 24) begin
                send_frame(FR_BAD_VERSION, 32'h0);
            end else begin
                send_frame(($urandom_range(0, 1) == 0) ? FR_GOOD_A : FR_GOOD_B,
                           {rand_byte(), rand_byte(), rand_byte(), rand_byte()});
            end
        end

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
